FILE: src/rmj_pkg.sv
package rmj_pkg;

  localparam int FRAC_BITS = 16;           // Q format fraction bits
  localparam int DataW     = 32;           // field width
  localparam int ThrW      = 31;           // threshold register width
  localparam int SqW       = 2 * DataW;    // squared distance width
  localparam int RootW     = SqW / 2;      // sqrt result width
  localparam int SqRemW    = RootW + 2;    // sqrt partial remainder width
  localparam int QuoW      = DataW;        // quotient bits kept
  localparam int DenW      = RootW + SqW;  // widest divisor, r * S
  localparam int NumW      = DenW + QuoW;  // numerator width
  localparam int RemW      = DenW + 1;     // divider partial remainder width
  localparam int Lanes     = 6;            // six quotients per word
  localparam int DenCnt    = Lanes / 2;    // lanes share divisors in pairs
  localparam int SqSteps   = RootW;        // one root bit per cell
  localparam int DivSteps  = QuoW;         // one quotient bit per cell

  localparam logic [ThrW-1:0] MinDistSqRst = ThrW'(7);

  typedef struct packed {
    logic signed [DataW-1:0] pos_x;
    logic signed [DataW-1:0] pos_y;
    logic signed [DataW-1:0] vel_x;
    logic signed [DataW-1:0] vel_y;
  } in_t;

  typedef struct packed {
    logic signed [DataW-1:0] range_dx;
    logic signed [DataW-1:0] range_dy;
    logic signed [DataW-1:0] bearing_dx;
    logic signed [DataW-1:0] bearing_dy;
    logic signed [DataW-1:0] rate_dx;
    logic signed [DataW-1:0] rate_dy;
    logic                    degenerate;
  } res_t;

  // word moving down the square root chain, with the sideband data
  typedef struct packed {
    logic [SqRemW-1:0] rem;
    logic [RootW-1:0]  root;
    logic [SqW-1:0]    nrem;
    logic [SqW-1:0]    s;
    logic [SqW-1:0]    dmag;
    logic [DataW-1:0]  apx;
    logic [DataW-1:0]  apy;
    logic              dneg;
    logic              pxn;
    logic              pyn;
    logic              pyp;
    logic              degen;
  } sq_word_t;

  typedef struct packed {
    logic [RemW-1:0] rem;
    logic [QuoW-1:0] nlo;
    logic [QuoW-1:0] quo;
  } div_lane_t;

  // word moving down the divider chain
  typedef struct packed {
    div_lane_t [Lanes-1:0]           lane;
    logic      [DenCnt-1:0][DenW-1:0] den;
    logic      [Lanes-1:0]           neg;
    logic      [Lanes-1:0]           ovf;
    logic                            degen;
  } div_word_t;

  // sign and saturate a truncated quotient magnitude
  function automatic logic [DataW-1:0] sat_q(input logic neg, input logic ovf,
                                             input logic [QuoW-1:0] quo);
    logic big;
    big = ovf | quo[QuoW-1];
    if (neg) begin
      sat_q = big ? {1'b1, {(DataW-1){1'b0}}} : DataW'(~quo + 1'b1);
    end else begin
      sat_q = big ? {1'b0, {(DataW-1){1'b1}}} : DataW'(quo);
    end
  endfunction

endpackage

FILE: src/rmj_sqrt_cell.sv
module rmj_sqrt_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  rmj_pkg::sq_word_t word_i,
  output logic              valid_o,
  output rmj_pkg::sq_word_t word_o
);

  rmj_pkg::sq_word_t word_d, word_q;
  logic              valid_q;
  logic [rmj_pkg::SqRemW+1:0] rs;
  logic [rmj_pkg::SqRemW+1:0] trial;
  logic                       ge;

  // one restoring sqrt step: bring down two bits, try 4*root+1
  always_comb begin
    rs     = {word_i.rem, word_i.nrem[rmj_pkg::SqW-1 -: 2]};
    trial  = {2'b00, word_i.root, 2'b01};
    ge     = rs >= trial;
    word_d = word_i;
    word_d.rem  = ge ? rmj_pkg::SqRemW'(rs - trial) : rmj_pkg::SqRemW'(rs);
    word_d.root = {word_i.root[rmj_pkg::RootW-2:0], ge};
    word_d.nrem = {word_i.nrem[rmj_pkg::SqW-3:0], 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

FILE: src/rmj_div_cell.sv
module rmj_div_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  rmj_pkg::div_word_t word_i,
  output logic               valid_o,
  output rmj_pkg::div_word_t word_o
);

  rmj_pkg::div_word_t word_d, word_q;
  logic               valid_q;
  logic [rmj_pkg::RemW-1:0] rs;
  logic [rmj_pkg::RemW-1:0] dv;
  logic                     ge;

  // one restoring division step on each of the six lanes
  always_comb begin
    rs     = '0;
    dv     = '0;
    ge     = 1'b0;
    word_d = word_i;
    for (int l = 0; l < rmj_pkg::Lanes; l++) begin
      rs = {word_i.lane[l].rem[rmj_pkg::RemW-2:0], word_i.lane[l].nlo[rmj_pkg::QuoW-1]};
      dv = {1'b0, word_i.den[l >> 1]};
      ge = rs >= dv;
      word_d.lane[l].rem = ge ? rs - dv : rs;
      word_d.lane[l].nlo = {word_i.lane[l].nlo[rmj_pkg::QuoW-2:0], 1'b0};
      word_d.lane[l].quo = {word_i.lane[l].quo[rmj_pkg::QuoW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

FILE: src/radar_measurement_jacobian.sv
// Radar measurement Jacobian, fully pipelined.
// Every stage is registered, from the start capture to the result word register.
// Throughput: one word per cycle; busy stays low and the receiver cannot stall.
// Most of the registers lie in the 32-cell square root chain and the 32-cell divider chain.
// Reset (async, active low) empties the pipeline and sets min_dist_sq to 7.
module radar_measurement_jacobian (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  rmj_pkg::in_t                  in_i,
  output logic                          res_valid_o,
  output rmj_pkg::res_t                 res_o,
  input  logic                          cfg_we_i,
  input  logic [rmj_pkg::ThrW-1:0]      cfg_data_i
);

  localparam int F = rmj_pkg::FRAC_BITS;
  localparam int W = rmj_pkg::DataW;

  // config register; the user must write it only while idle, the block does not enforce it
  logic [rmj_pkg::ThrW-1:0] min_dist_sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_dist_sq_q <= rmj_pkg::MinDistSqRst;
    end else if (cfg_we_i) begin
      min_dist_sq_q <= cfg_data_i;
    end
  end

  // no stall anywhere in the pipe
  assign busy = 1'b0;

  logic accept;
  assign accept = start & ~busy;

  // ---------------------------------------------------------------
  // stage 1: capture the word
  // ---------------------------------------------------------------
  rmj_pkg::in_t in_q;
  logic         v1_q;

  // stage 2: magnitudes and sign flags
  logic [W-1:0]        apx2_q, apy2_q;
  logic signed [W-1:0] px2_q, py2_q, vx2_q, vy2_q;
  logic                pxn2_q, pyn2_q, pyp2_q, v2_q;
  logic [W-1:0]        apx2_d, apy2_d;

  // stage 3: products
  logic [rmj_pkg::SqW-1:0]        sqx3_q, sqy3_q;
  logic signed [rmj_pkg::SqW-1:0] a3_q, b3_q;
  logic [W-1:0]                   apx3_q, apy3_q;
  logic                           pxn3_q, pyn3_q, pyp3_q, v3_q;

  // stage 4: distance, cross term, threshold test -> head of sqrt chain
  rmj_pkg::sq_word_t sq4_d, sq4_q;
  logic              v4_q;
  logic [rmj_pkg::SqW-1:0] s4, thr4;

  always_comb begin
    apx2_d = in_q.pos_x[W-1] ? W'(~in_q.pos_x + 1'b1) : W'(in_q.pos_x);
    apy2_d = in_q.pos_y[W-1] ? W'(~in_q.pos_y + 1'b1) : W'(in_q.pos_y);
  end

  always_comb begin
    s4   = sqx3_q + sqy3_q;
    thr4 = rmj_pkg::SqW'({min_dist_sq_q, {F{1'b0}}});
    sq4_d       = '0;
    sq4_d.nrem  = s4;
    sq4_d.s     = s4;
    sq4_d.dneg  = a3_q < b3_q;
    sq4_d.dmag  = (a3_q < b3_q) ? rmj_pkg::SqW'(b3_q - a3_q) : rmj_pkg::SqW'(a3_q - b3_q);
    sq4_d.apx   = apx3_q;
    sq4_d.apy   = apy3_q;
    sq4_d.pxn   = pxn3_q;
    sq4_d.pyn   = pyn3_q;
    sq4_d.pyp   = pyp3_q;
    sq4_d.degen = s4 <= thr4;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_i;
    end
    apx2_q <= apx2_d;
    apy2_q <= apy2_d;
    px2_q  <= in_q.pos_x;
    py2_q  <= in_q.pos_y;
    vx2_q  <= in_q.vel_x;
    vy2_q  <= in_q.vel_y;
    pxn2_q <= in_q.pos_x[W-1];
    pyn2_q <= in_q.pos_y[W-1];
    pyp2_q <= ~in_q.pos_y[W-1] & (in_q.pos_y != '0);

    sqx3_q <= rmj_pkg::SqW'(apx2_q) * rmj_pkg::SqW'(apx2_q);
    sqy3_q <= rmj_pkg::SqW'(apy2_q) * rmj_pkg::SqW'(apy2_q);
    a3_q   <= rmj_pkg::SqW'(vx2_q) * rmj_pkg::SqW'(py2_q);
    b3_q   <= rmj_pkg::SqW'(vy2_q) * rmj_pkg::SqW'(px2_q);
    apx3_q <= apx2_q;
    apy3_q <= apy2_q;
    pxn3_q <= pxn2_q;
    pyn3_q <= pyn2_q;
    pyp3_q <= pyp2_q;

    sq4_q <= sq4_d;
  end

  // ---------------------------------------------------------------
  // square root chain: one root bit per cell
  // ---------------------------------------------------------------
  rmj_pkg::sq_word_t sq_w [rmj_pkg::SqSteps+1];
  logic              sq_v [rmj_pkg::SqSteps+1];

  assign sq_w[0] = sq4_q;
  assign sq_v[0] = v4_q;

  for (genvar i = 0; i < rmj_pkg::SqSteps; i++) begin : g_sqrt
    rmj_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sq_v[i]),
      .word_i  (sq_w[i]),
      .valid_o (sq_v[i+1]),
      .word_o  (sq_w[i+1])
    );
  end

  rmj_pkg::sq_word_t sq_end;
  assign sq_end = sq_w[rmj_pkg::SqSteps];

  // ---------------------------------------------------------------
  // stage 5: 32x32 partial products of r*S, dmag*|py|, dmag*|px|
  // ---------------------------------------------------------------
  localparam int HW = rmj_pkg::SqW / 2;
  localparam int PW = 2 * HW;

  logic [PW-1:0] rs_lo5_q, rs_hi5_q, ny_lo5_q, ny_hi5_q, nx_lo5_q, nx_hi5_q;
  rmj_pkg::sq_word_t sb5_q;
  logic              v5_q;

  // stage 6: sum the partials
  logic [rmj_pkg::DenW-1:0] rs6_q, ny6_q, nx6_q;
  rmj_pkg::sq_word_t        sb6_q;
  logic                     v6_q;

  // stage 7: divider setup -> head of divider chain
  rmj_pkg::div_word_t              dv7_d, dv7_q;
  logic                            v7_q;
  logic [rmj_pkg::Lanes-1:0][rmj_pkg::NumW-1:0] num7;
  logic [rmj_pkg::DenW-1:0]        nhi7;

  always_comb begin
    num7[0] = rmj_pkg::NumW'(sb6_q.apx) << F;
    num7[1] = rmj_pkg::NumW'(sb6_q.apy) << F;
    num7[2] = rmj_pkg::NumW'(sb6_q.apy) << (2 * F);
    num7[3] = rmj_pkg::NumW'(sb6_q.apx) << (2 * F);
    num7[4] = rmj_pkg::NumW'(ny6_q) << F;
    num7[5] = rmj_pkg::NumW'(nx6_q) << F;

    dv7_d        = '0;
    dv7_d.den[0] = rmj_pkg::DenW'(sb6_q.root);
    dv7_d.den[1] = rmj_pkg::DenW'(sb6_q.s);
    dv7_d.den[2] = rs6_q;
    dv7_d.neg    = {sb6_q.pxn == sb6_q.dneg, sb6_q.pyn != sb6_q.dneg,
                    sb6_q.pxn, sb6_q.pyp, sb6_q.pyn, sb6_q.pxn};
    dv7_d.degen  = sb6_q.degen;
    nhi7         = '0;
    // quotients of 2^32 or more saturate; otherwise the top part is below the divisor
    for (int l = 0; l < rmj_pkg::Lanes; l++) begin
      nhi7              = num7[l][rmj_pkg::NumW-1:rmj_pkg::QuoW];
      dv7_d.ovf[l]      = nhi7 >= dv7_d.den[l >> 1];
      dv7_d.lane[l].rem = dv7_d.ovf[l] ? '0 : rmj_pkg::RemW'(nhi7);
      dv7_d.lane[l].nlo = num7[l][rmj_pkg::QuoW-1:0];
      dv7_d.lane[l].quo = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else begin
      v5_q <= sq_v[rmj_pkg::SqSteps];
      v6_q <= v5_q;
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rs_lo5_q <= PW'(sq_end.root) * PW'(sq_end.s[HW-1:0]);
    rs_hi5_q <= PW'(sq_end.root) * PW'(sq_end.s[rmj_pkg::SqW-1:HW]);
    ny_lo5_q <= PW'(sq_end.apy) * PW'(sq_end.dmag[HW-1:0]);
    ny_hi5_q <= PW'(sq_end.apy) * PW'(sq_end.dmag[rmj_pkg::SqW-1:HW]);
    nx_lo5_q <= PW'(sq_end.apx) * PW'(sq_end.dmag[HW-1:0]);
    nx_hi5_q <= PW'(sq_end.apx) * PW'(sq_end.dmag[rmj_pkg::SqW-1:HW]);
    sb5_q    <= sq_end;

    rs6_q <= rmj_pkg::DenW'(rs_lo5_q) + (rmj_pkg::DenW'(rs_hi5_q) << HW);
    ny6_q <= rmj_pkg::DenW'(ny_lo5_q) + (rmj_pkg::DenW'(ny_hi5_q) << HW);
    nx6_q <= rmj_pkg::DenW'(nx_lo5_q) + (rmj_pkg::DenW'(nx_hi5_q) << HW);
    sb6_q <= sb5_q;

    dv7_q <= dv7_d;
  end

  // ---------------------------------------------------------------
  // divider chain: one quotient bit per cell on all six lanes
  // ---------------------------------------------------------------
  rmj_pkg::div_word_t div_w [rmj_pkg::DivSteps+1];
  logic               div_v [rmj_pkg::DivSteps+1];

  assign div_w[0] = dv7_q;
  assign div_v[0] = v7_q;

  for (genvar i = 0; i < rmj_pkg::DivSteps; i++) begin : g_div
    rmj_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (div_v[i]),
      .word_i  (div_w[i]),
      .valid_o (div_v[i+1]),
      .word_o  (div_w[i+1])
    );
  end

  // ---------------------------------------------------------------
  // output register: sign, saturate, zero on degenerate
  // ---------------------------------------------------------------
  rmj_pkg::div_word_t div_end;
  rmj_pkg::res_t      res_d, res_q;
  logic               res_valid_q;

  assign div_end = div_w[rmj_pkg::DivSteps];

  always_comb begin
    res_d            = '0;
    res_d.degenerate = div_end.degen;
    if (!div_end.degen) begin
      res_d.range_dx   = rmj_pkg::sat_q(div_end.neg[0], div_end.ovf[0], div_end.lane[0].quo);
      res_d.range_dy   = rmj_pkg::sat_q(div_end.neg[1], div_end.ovf[1], div_end.lane[1].quo);
      res_d.bearing_dx = rmj_pkg::sat_q(div_end.neg[2], div_end.ovf[2], div_end.lane[2].quo);
      res_d.bearing_dy = rmj_pkg::sat_q(div_end.neg[3], div_end.ovf[3], div_end.lane[3].quo);
      res_d.rate_dx    = rmj_pkg::sat_q(div_end.neg[4], div_end.ovf[4], div_end.lane[4].quo);
      res_d.rate_dy    = rmj_pkg::sat_q(div_end.neg[5], div_end.ovf[5], div_end.lane[5].quo);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= div_v[rmj_pkg::DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // ---------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------
  localparam logic signed [W-1:0] One = W'(1) << F;

  // root leaving the chain never exceeds sqrt(S)
  a_root_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_v[rmj_pkg::SqSteps] |->
      (rmj_pkg::SqW'(sq_end.root) * rmj_pkg::SqW'(sq_end.root)) <= sq_end.s)
    else $error("sqrt chain root too large");

  // degenerate word carries all-zero partials
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.degenerate) |->
      (res_o.range_dx == '0 && res_o.range_dy == '0 && res_o.bearing_dx == '0 &&
       res_o.bearing_dy == '0 && res_o.rate_dx == '0 && res_o.rate_dy == '0))
    else $error("degenerate result not zero");

  // |px| / r and |py| / r stay within unit magnitude
  a_range_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.degenerate) |->
      (res_o.range_dx <= One && res_o.range_dx >= -One &&
       res_o.range_dy <= One && res_o.range_dy >= -One))
    else $error("range partial exceeds one");

endmodule
